/* hw/rtl/bfk_pkg.sv */
// Shared constants, types and fixed-point helpers for the bunch feedback FIR kick unit.
// Used by every other file in hw/rtl except bfk_ram; depends on nothing.
`default_nettype none

package bfk_pkg;

    localparam int NUM_BUNCHES = 64;
    localparam int MAX_TAPS    = 16;
    localparam int MAX_DELAY   = 16;
    localparam int SAMPLE_W    = 18;

    // Fixed field widths of the item and the configuration registers.
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 6;
    localparam int TAPS_CFG_W = 5;
    localparam int LIMIT_W    = 17;
    localparam int GCNT_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int TURN_W     = 16;
    localparam int TURN_BIT_W = 4;

    localparam int BUNCH_W  = $clog2(NUM_BUNCHES);
    localparam int TAP_W    = $clog2(MAX_TAPS);
    localparam int RING_LEN = MAX_DELAY + MAX_TAPS;
    localparam int RING_W   = $clog2(RING_LEN);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int LEN_W    = $clog2(RING_LEN + 1) + 1;
    localparam int PH_DEPTH = NUM_BUNCHES * MAX_TAPS;
    localparam int DH_DEPTH = NUM_BUNCHES * RING_LEN;
    localparam int PH_AW    = BUNCH_W + TAP_W;
    localparam int DH_AW    = BUNCH_W + RING_W;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + TAP_W + 1;
    localparam int SHIFT    = 16;

    localparam int SAT_HI = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAT_LO = -SAT_HI - 1;
    localparam logic signed [ACC_W-1:0] ACC_HI    = ACC_W'(SAT_HI);
    localparam logic signed [ACC_W-1:0] ACC_LO    = ACC_W'(SAT_LO);
    localparam logic signed [ACC_W:0]   ACC_ROUND = (ACC_W+1)'(1 << (SHIFT - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_PCOEF  = 2'd1,
        CMD_DCOEF  = 2'd2,
        CMD_GAIN   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PICKUP_TAPS = 3'd0,
        CFG_DRIVER_TAPS = 3'd1,
        CFG_DRIVER_DLY  = 3'd2,
        CFG_OFFSET      = 3'd3,
        CFG_STRENGTH    = 3'd4,
        CFG_KICK_LIMIT  = 3'd5,
        CFG_GLOBAL_GAIN = 3'd6,
        CFG_GAIN_COUNT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_MAC  = 2'd0,
        MUL_STR  = 2'd1,
        MUL_GAIN = 2'd2,
        MUL_GLOB = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     ready;
        logic     clear;
        logic     mod_step;
        logic     p_write;
        logic     mac_step;
        logic     sel_driver;
        logic     p_res;
        logic     d_write;
        logic     d_res;
        logic     mul_load;
        mul_sel_t mul_sel;
        logic     g_scale;
        logic     finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic sample_go;
        logic mod_last;
        logic mac_done;
        logic out_free;
    } dp_status_t;

    function automatic sample_t sat_acc(input logic signed [ACC_W-1:0] v);
        sample_t r;
        if (v > ACC_HI)
            r = sample_t'(SAT_HI);
        else if (v < ACC_LO)
            r = sample_t'(SAT_LO);
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // Shift right by 16 with rounding half toward plus infinity, then saturate.
    function automatic sample_t scale16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0]   x;
        logic signed [ACC_W-1:0] s;
        x = {v[ACC_W-1], v} + ACC_ROUND;
        s = ACC_W'(x >>> SHIFT);
        return sat_acc(s);
    endfunction

    function automatic logic [CNT_W-1:0] clamp_taps(input logic [TAPS_CFG_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n == '0)
            r = CNT_W'(1);
        else if (n > TAPS_CFG_W'(MAX_TAPS))
            r = CNT_W'(MAX_TAPS);
        else
            r = CNT_W'(n);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bfk_req_if.sv */
// Input channel of the kick unit: valid/ready handshake with the item payload.
// Depends on bfk_pkg for field widths.
`default_nettype none

interface bfk_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfk_pkg::CMD_W-1:0]   cmd;
    logic [bfk_pkg::ADDR_W-1:0]  bunch_or_addr;
    bfk_pkg::sample_t            value;
    logic                        end_of_turn;

    modport source (output valid, output cmd, output bunch_or_addr, output value,
                    output end_of_turn, input ready);
    modport sink   (input valid, input cmd, input bunch_or_addr, input value,
                    input end_of_turn, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bfk_rsp_if.sv */
// Result channel of the kick unit: valid/ready handshake with the kick payload.
// Depends on bfk_pkg for field widths.
`default_nettype none

interface bfk_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfk_pkg::ADDR_W-1:0]   out_bunch;
    bfk_pkg::sample_t             pickup_result;
    bfk_pkg::sample_t             kick_value;
    logic                         driver_active;
    logic                         out_end_of_turn;

    modport source (output valid, output out_bunch, output pickup_result,
                    output kick_value, output driver_active, output out_end_of_turn,
                    input ready);
    modport sink   (input valid, input out_bunch, input pickup_result,
                    input kick_value, input driver_active, input out_end_of_turn,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/bfk_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the history rings and the bunch gain table.
`default_nettype none

module bfk_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire                        clk,
    input  wire                        we,
    input  wire  [$clog2(DEPTH)-1:0]   waddr,
    input  wire  [WIDTH-1:0]           wdata,
    input  wire                        re,
    input  wire  [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bfk_ctrl.sv */
// Sequencer of the kick unit: clearing pass, then one sample at a time through
// modulo, pickup FIR, driver FIR and gain steps. Depends on bfk_pkg.
`default_nettype none

module bfk_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  bfk_pkg::dp_status_t  status,
    output bfk_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [13:0] {
        S_CLEAR  = 14'h0001,
        S_IDLE   = 14'h0002,
        S_MOD    = 14'h0004,
        S_PWRITE = 14'h0008,
        S_PMAC   = 14'h0010,
        S_PRES   = 14'h0020,
        S_PSTR   = 14'h0040,
        S_DWRITE = 14'h0080,
        S_DMAC   = 14'h0100,
        S_DRES   = 14'h0200,
        S_GMUL   = 14'h0400,
        S_GSCALE = 14'h0800,
        S_KMUL   = 14'h1000,
        S_FIN    = 14'h2000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = bfk_pkg::MUL_MAC;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.sample_go)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                    state_next = S_PWRITE;
            end
            S_PWRITE:
            begin
                cmd.p_write = 1'b1;
                state_next  = S_PMAC;
            end
            S_PMAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.mac_done)
                    state_next = S_PRES;
            end
            S_PRES:
            begin
                cmd.p_res  = 1'b1;
                state_next = S_PSTR;
            end
            S_PSTR:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = bfk_pkg::MUL_STR;
                state_next   = S_DWRITE;
            end
            S_DWRITE:
            begin
                cmd.d_write = 1'b1;
                state_next  = S_DMAC;
            end
            S_DMAC:
            begin
                cmd.mac_step   = 1'b1;
                cmd.sel_driver = 1'b1;
                if (status.mac_done)
                    state_next = S_DRES;
            end
            S_DRES:
            begin
                cmd.sel_driver = 1'b1;
                cmd.d_res      = 1'b1;
                state_next     = S_GMUL;
            end
            S_GMUL:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = bfk_pkg::MUL_GAIN;
                state_next   = S_GSCALE;
            end
            S_GSCALE:
            begin
                cmd.g_scale = 1'b1;
                state_next  = S_KMUL;
            end
            S_KMUL:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = bfk_pkg::MUL_GLOB;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // A sample leaves the pickup filter loop only after its accumulator has drained.
    a_pmac_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PMAC && state_next == S_PRES) |-> status.mac_done)
        else $error("pickup filter left before it finished");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass entered outside reset");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result produced while output register still full");

endmodule

`default_nettype wire

/* hw/rtl/bfk_datapath.sv */
// Datapath of the kick unit: config registers, coefficient tables, history RAMs,
// modulo unit, shared multiply-accumulate and the output register. Depends on
// bfk_pkg, bfk_req_if, bfk_rsp_if and bfk_ram.
`default_nettype none

module bfk_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  bfk_pkg::ctrl_cmd_t               cmd,
    output bfk_pkg::dp_status_t              status,
    bfk_req_if.sink                          req,
    bfk_rsp_if.source                        rsp,
    input  wire                              cfg_wen,
    input  wire [bfk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [bfk_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW  = bfk_pkg::SAMPLE_W;
    localparam int AW  = bfk_pkg::ACC_W;
    localparam int LW  = bfk_pkg::LEN_W;
    localparam int RW  = bfk_pkg::RING_W;
    localparam int TW  = bfk_pkg::TAP_W;
    localparam int BW  = bfk_pkg::BUNCH_W;
    localparam int NW  = bfk_pkg::CNT_W;
    localparam int TNW = bfk_pkg::TURN_W;

    // Configuration registers.
    logic [bfk_pkg::TAPS_CFG_W-1:0] ptaps_reg, dtaps_reg, delay_reg;
    bfk_pkg::sample_t               offset_reg, strength_reg, global_reg;
    logic [bfk_pkg::LIMIT_W-1:0]    limit_reg;
    logic [bfk_pkg::GCNT_W-1:0]     gcount_reg;

    bfk_pkg::sample_t pcoef_reg [bfk_pkg::MAX_TAPS];
    bfk_pkg::sample_t dcoef_reg [bfk_pkg::MAX_TAPS];

    logic [TNW-1:0]                 t_reg;
    logic [BW-1:0]                  bunch_reg;
    bfk_pkg::sample_t               val_reg;
    logic                           eot_reg;
    logic [bfk_pkg::TURN_BIT_W-1:0] bitcnt_reg;
    logic [LW-1:0]                  rem_p_reg, rem_d_reg;
    logic [bfk_pkg::DH_AW-1:0]      clr_reg;
    logic [RW-1:0]                  slot_reg;
    logic [NW-1:0]                  issue_reg;
    logic [TW-1:0]                  tap_reg;
    logic                           rd_v_reg, mul_v_reg;
    logic signed [bfk_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]           acc_reg;
    bfk_pkg::sample_t               pres_reg, kick_reg;
    logic                           active_reg;

    logic                           ov_reg;
    logic [bfk_pkg::ADDR_W-1:0]     ob_reg;
    bfk_pkg::sample_t               opres_reg, okick_reg;
    logic                           oact_reg, oeot_reg;

    // Derived per-configuration values.
    logic [NW-1:0] pt, dt, mac_n;
    logic [LW-1:0] dl, rlen, wrap_n, d_start, shp_p, shp_d;
    logic [RW-1:0] slot_dec;
    logic          tbit, issue_go, p_live, active, use_gain, in_accept;
    logic          addr_bunch_ok, addr_tap_ok, turn_adv;
    logic signed [SW:0] diff;
    bfk_pkg::sample_t mul_a, mul_b, lim_s, kick_clamped, gain_q, prd_q, drd_q;
    logic signed [bfk_pkg::PROD_W-1:0] prod;
    logic [SW-1:0] prdata, drdata, grdata;

    always_comb
    begin
        pt     = bfk_pkg::clamp_taps(ptaps_reg);
        dt     = bfk_pkg::clamp_taps(dtaps_reg);
        dl     = (delay_reg > bfk_pkg::TAPS_CFG_W'(bfk_pkg::MAX_DELAY)) ?
                 LW'(bfk_pkg::MAX_DELAY) : LW'(delay_reg);
        rlen   = dl + LW'(dt);
        wrap_n = cmd.sel_driver ? rlen : LW'(pt);
        mac_n  = cmd.sel_driver ? dt : pt;
        slot_dec = (slot_reg == '0) ? RW'(wrap_n - LW'(1)) : slot_reg - RW'(1);
        d_start  = (rem_d_reg >= dl) ? rem_d_reg - dl : rem_d_reg + rlen - dl;

        tbit  = t_reg[bitcnt_reg];
        shp_p = {rem_p_reg[LW-2:0], tbit};
        shp_d = {rem_d_reg[LW-2:0], tbit};

        issue_go = cmd.mac_step && (issue_reg < mac_n);
        p_live   = t_reg >= TNW'(pt);
        active   = t_reg >= TNW'(rlen);
        use_gain = bfk_pkg::GCNT_W'(bunch_reg) < gcount_reg;

        in_accept     = req.valid && cmd.ready;
        addr_bunch_ok = {1'b0, req.bunch_or_addr} <
                        (bfk_pkg::ADDR_W+1)'(bfk_pkg::NUM_BUNCHES);
        addr_tap_ok   = {1'b0, req.bunch_or_addr} <
                        (bfk_pkg::ADDR_W+1)'(bfk_pkg::MAX_TAPS);

        diff = {val_reg[SW-1], val_reg} - {offset_reg[SW-1], offset_reg};

        lim_s = bfk_pkg::sample_t'({1'b0, limit_reg});
        kick_clamped = kick_reg;
        if (limit_reg != '0)
        begin
            if (kick_reg > lim_s)
                kick_clamped = lim_s;
            else if (kick_reg < -lim_s)
                kick_clamped = -lim_s;
        end

        gain_q = bfk_pkg::sample_t'(grdata);
        prd_q  = bfk_pkg::sample_t'(prdata);
        drd_q  = bfk_pkg::sample_t'(drdata);

        case (cmd.mul_sel)
            bfk_pkg::MUL_STR:
            begin
                mul_a = pres_reg;
                mul_b = strength_reg;
            end
            bfk_pkg::MUL_GAIN:
            begin
                mul_a = kick_reg;
                mul_b = gain_q;
            end
            bfk_pkg::MUL_GLOB:
            begin
                mul_a = kick_clamped;
                mul_b = global_reg;
            end
            default:
            begin
                mul_a = cmd.sel_driver ? dcoef_reg[tap_reg] : pcoef_reg[tap_reg];
                mul_b = cmd.sel_driver ? drd_q : prd_q;
            end
        endcase
        prod = mul_a * mul_b;

        turn_adv = ((cmd.finish && eot_reg) ||
                    (in_accept && req.cmd == bfk_pkg::CMD_SAMPLE && !addr_bunch_ok &&
                     req.end_of_turn)) && (t_reg != '1);
    end

    // History rings and gain table.
    bfk_ram #(.WIDTH(SW), .DEPTH(bfk_pkg::PH_DEPTH)) u_pickup_ram (
        .clk   (clk),
        .we    (cmd.clear || cmd.p_write),
        .waddr (cmd.clear ? clr_reg[bfk_pkg::PH_AW-1:0] : {bunch_reg, rem_p_reg[TW-1:0]}),
        .wdata (cmd.clear ? '0 : bfk_pkg::sat_acc(AW'(diff))),
        .re    (issue_go && !cmd.sel_driver),
        .raddr ({bunch_reg, slot_reg[TW-1:0]}),
        .rdata (prdata)
    );

    bfk_ram #(.WIDTH(SW), .DEPTH(bfk_pkg::DH_DEPTH)) u_driver_ram (
        .clk   (clk),
        .we    (cmd.clear || cmd.d_write),
        .waddr (cmd.clear ? clr_reg : {bunch_reg, rem_d_reg[RW-1:0]}),
        .wdata (cmd.clear ? '0 : bfk_pkg::scale16(AW'(prod_reg))),
        .re    (issue_go && cmd.sel_driver),
        .raddr ({bunch_reg, slot_reg}),
        .rdata (drdata)
    );

    bfk_ram #(.WIDTH(SW), .DEPTH(bfk_pkg::NUM_BUNCHES)) u_gain_ram (
        .clk   (clk),
        .we    (cmd.clear || (in_accept && req.cmd == bfk_pkg::CMD_GAIN && addr_bunch_ok)),
        .waddr (cmd.clear ? clr_reg[BW-1:0] : req.bunch_or_addr[BW-1:0]),
        .wdata (cmd.clear ? '0 : req.value),
        .re    (cmd.p_write),
        .raddr (bunch_reg),
        .rdata (grdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptaps_reg    <= bfk_pkg::TAPS_CFG_W'(1);
            dtaps_reg    <= bfk_pkg::TAPS_CFG_W'(1);
            delay_reg    <= '0;
            offset_reg   <= '0;
            strength_reg <= bfk_pkg::sample_t'(65536);
            limit_reg    <= '0;
            global_reg   <= bfk_pkg::sample_t'(65536);
            gcount_reg   <= '0;
            for (int i = 0; i < bfk_pkg::MAX_TAPS; i++)
            begin
                pcoef_reg[i] <= '0;
                dcoef_reg[i] <= '0;
            end
            t_reg     <= '0;
            clr_reg   <= '0;
            issue_reg <= '0;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (bfk_pkg::cfg_idx_t'(cfg_index))
                    bfk_pkg::CFG_PICKUP_TAPS: ptaps_reg  <= cfg_data[bfk_pkg::TAPS_CFG_W-1:0];
                    bfk_pkg::CFG_DRIVER_TAPS: dtaps_reg  <= cfg_data[bfk_pkg::TAPS_CFG_W-1:0];
                    bfk_pkg::CFG_DRIVER_DLY:  delay_reg  <= cfg_data[bfk_pkg::TAPS_CFG_W-1:0];
                    bfk_pkg::CFG_OFFSET:      offset_reg <= bfk_pkg::sample_t'(cfg_data);
                    bfk_pkg::CFG_STRENGTH:    strength_reg <= bfk_pkg::sample_t'(cfg_data);
                    bfk_pkg::CFG_KICK_LIMIT:  limit_reg  <= cfg_data[bfk_pkg::LIMIT_W-1:0];
                    bfk_pkg::CFG_GLOBAL_GAIN: global_reg <= bfk_pkg::sample_t'(cfg_data);
                    bfk_pkg::CFG_GAIN_COUNT:  gcount_reg <= cfg_data[bfk_pkg::GCNT_W-1:0];
                    default:                  gcount_reg <= gcount_reg;
                endcase
            end
            if (in_accept && addr_tap_ok)
            begin
                if (req.cmd == bfk_pkg::CMD_PCOEF)
                    pcoef_reg[req.bunch_or_addr[TW-1:0]] <= req.value;
                if (req.cmd == bfk_pkg::CMD_DCOEF)
                    dcoef_reg[req.bunch_or_addr[TW-1:0]] <= req.value;
            end
            if (turn_adv)
                t_reg <= t_reg + TNW'(1);
            if (cmd.clear)
                clr_reg <= clr_reg + bfk_pkg::DH_AW'(1);

            if (cmd.p_write || cmd.d_write)
            begin
                issue_reg <= '0;
                rd_v_reg  <= 1'b0;
                mul_v_reg <= 1'b0;
            end
            else
            begin
                if (issue_go)
                    issue_reg <= issue_reg + NW'(1);
                rd_v_reg  <= issue_go;
                mul_v_reg <= rd_v_reg;
            end

            if (cmd.finish)
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bunch_reg  <= req.bunch_or_addr[BW-1:0];
            val_reg    <= req.value;
            eot_reg    <= req.end_of_turn;
            bitcnt_reg <= bfk_pkg::TURN_BIT_W'(TNW - 1);
            rem_p_reg  <= '0;
            rem_d_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            bitcnt_reg <= bitcnt_reg - bfk_pkg::TURN_BIT_W'(1);
            rem_p_reg  <= (shp_p >= LW'(pt)) ? shp_p - LW'(pt) : shp_p;
            rem_d_reg  <= (shp_d >= rlen) ? shp_d - rlen : shp_d;
        end
        if (cmd.p_write)
            slot_reg <= RW'(rem_p_reg);
        else if (cmd.d_write)
            slot_reg <= d_start[RW-1:0];
        else if (issue_go)
            slot_reg <= slot_dec;
        if (issue_go)
            tap_reg <= issue_reg[TW-1:0];

        if ((cmd.mac_step && rd_v_reg) || cmd.mul_load)
            prod_reg <= prod;
        if (cmd.p_write || cmd.d_write)
            acc_reg <= '0;
        else if (cmd.mac_step && mul_v_reg)
            acc_reg <= acc_reg + AW'(prod_reg);

        if (cmd.p_res)
            pres_reg <= p_live ? bfk_pkg::scale16(acc_reg) : '0;
        if (cmd.d_res)
        begin
            kick_reg   <= active ? bfk_pkg::scale16(acc_reg) : '0;
            active_reg <= active;
        end
        else if (cmd.g_scale && use_gain)
            kick_reg <= bfk_pkg::scale16(AW'(prod_reg));

        if (cmd.finish)
        begin
            ob_reg    <= bfk_pkg::ADDR_W'(bunch_reg);
            opres_reg <= pres_reg;
            okick_reg <= bfk_pkg::scale16(AW'(prod_reg));
            oact_reg  <= active_reg;
            oeot_reg  <= eot_reg;
        end
    end

    assign req.ready = cmd.ready;

    assign rsp.valid           = ov_reg;
    assign rsp.out_bunch       = ob_reg;
    assign rsp.pickup_result   = opres_reg;
    assign rsp.kick_value      = okick_reg;
    assign rsp.driver_active   = oact_reg;
    assign rsp.out_end_of_turn = oeot_reg;

    assign status.clear_last = clr_reg == bfk_pkg::DH_AW'(bfk_pkg::DH_DEPTH - 1);
    assign status.sample_go  = in_accept && req.cmd == bfk_pkg::CMD_SAMPLE && addr_bunch_ok;
    assign status.mod_last   = bitcnt_reg == '0;
    assign status.mac_done   = !(issue_reg < mac_n) && !rd_v_reg && !mul_v_reg;
    assign status.out_free   = !ov_reg || rsp.ready;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_step |-> (LW'(slot_reg) < wrap_n))
        else $error("ring slot beyond ring length");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.p_write |-> (rem_p_reg < LW'(pt)) && (rem_d_reg < rlen))
        else $error("turn modulo out of range");

    a_turn_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (t_reg >= $past(t_reg)))
        else $error("turn count went backwards");

endmodule

`default_nettype wire

/* hw/rtl/bunch_feedback_fir_kick_unit.sv */
// Operation: an accepted sample runs through the 16-step turn modulo, the pickup FIR, the
// driver FIR and the gain steps on the shared multiply-accumulate; no new item is taken until
// its result is in the output register, which waits while that register is still full.
// Table and coefficient writes give no result.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the history RAMs
// and the gain table, during which no item is accepted (configuration writes are taken).
// Top level of the kick unit; depends on bfk_pkg, the channel interfaces, bfk_ctrl and
// bfk_datapath.
`default_nettype none

module bunch_feedback_fir_kick_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    bfk_req_if.sink                          req,
    bfk_rsp_if.source                        rsp,
    input  wire                              cfg_wen,
    input  wire [bfk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [bfk_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bfk_pkg::ctrl_cmd_t  cmd;
    bfk_pkg::dp_status_t status;

    bfk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    bfk_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
